@@ rtl/msf_pkg.sv @@
// msf_pkg: shared types, constants and codes for the maximal zero-set filter
// used by msf_ctrl, msf_datapath and maximal_zero_set_filter; no dependencies

package msf_pkg;

   // default capacities, handed to the top level parameters
   localparam int MAX_SURFACES_DEF = 64;
   localparam int MAX_TETS_DEF     = 16;

   // coordinate types per tetrahedron, one flag each for quad and octagon
   localparam int COORD_TYPES = 3;
   localparam int SUPPORT_W   = 2 * COORD_TYPES;
   localparam int INDEX_W     = 6;
   localparam int LOAD_CNT_W  = 7;
   localparam logic [LOAD_CNT_W-1:0] LOAD_LIMIT = 7'd64;
   localparam logic [LOAD_CNT_W-1:0] LOAD_MAX   = 7'd127;

   // support masks: quad flags only, or quad and octagon flags
   localparam logic [SUPPORT_W-1:0] MASK_QUAD = 6'h07;
   localparam logic [SUPPORT_W-1:0] MASK_ALL  = 6'h3F;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam int TET_COUNT_W = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALMOST_NORMAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TET_COUNT     = 2'd1;
   localparam logic [TET_COUNT_W-1:0] TET_COUNT_RESET   = 5'd1;

   // input beat: one tetrahedron record
   typedef struct packed {
      logic [COORD_TYPES-1:0] quad_nonzero;
      logic [COORD_TYPES-1:0] oct_nonzero;
      logic                   vertex_link;
      logic                   final_surface;
   } req_type;

   // output beat: one kept surface
   typedef struct packed {
      logic [INDEX_W-1:0] surface_index;
      logic               none_kept;
      logic               overflow;
      logic               last_result;
   } rsp_type;

   // controller states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_I_CHECK,
      ST_I_WAIT,
      ST_J_CHECK,
      ST_J_WAIT,
      ST_T_READ,
      ST_T_CMP,
      ST_EMIT,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic i_next;
      logic i_read;
      logic i_latch;
      logic j_next;
      logic j_read;
      logic j_latch;
      logic t_read;
      logic t_step;
      logic kill_i;
      logic emit;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic final_beat;
      logic i_done;
      logic i_live;
      logic j_done;
      logic j_skip;
      logic t_done;
      logic strict;
      logic contained;
      logic out_free;
   } status_type;

endpackage

@@ rtl/maximal_zero_set_filter.sv @@
// maximal_zero_set_filter: top level joining controller and datapath
// depends on msf_pkg, msf_ctrl and msf_datapath

// Surfaces load one tetrahedron record per cycle (req beat), with
// tet_count records per surface; vertex-linking surfaces take a load
// position but are not stored. The beat carrying final_surface starts the
// filter pass, during which req_ready is low. For each live surface i the
// pass walks every other live surface j and compares supports one
// tetrahedron at a time through the two read ports of the support memory:
// each live i has its index entry read and latched, a skipped j is passed
// over, a live j has its entry read and latched, and each tetrahedron is
// read and then compared (the compare stops at the first tetrahedron where
// j is not contained). A stall on the rsp side holds the pass until the
// output register is free. One rsp beat comes out per kept surface in
// load order; last_result marks the final one, and a run that keeps
// nothing gives a single beat with none_kept set. Configuration
// registers: index 0 almost_normal, index 1 tet_count; write them only
// while idle.
// The stores need no clearing after reset.

module maximal_zero_set_filter #(
   parameter int MAX_SURFACES = msf_pkg::MAX_SURFACES_DEF,
   parameter int MAX_TETS     = msf_pkg::MAX_TETS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [msf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [msf_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  msf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output msf_pkg::rsp_type                rsp_data
);

   msf_pkg::cmd_type    cmd;
   msf_pkg::status_type status;

   // sequencer
   msf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and compare
   msf_datapath #(
      .MAX_SURFACES (MAX_SURFACES),
      .MAX_TETS     (MAX_TETS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule

@@ rtl/msf_ctrl.sv @@
// msf_ctrl: sequencer for loading and the pairwise containment pass
// depends on msf_pkg (state, command and status types)

module msf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  msf_pkg::status_type  status,
   output msf_pkg::cmd_type     cmd
);

   msf_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msf_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msf_pkg::ST_LOAD: begin
            if (req_valid && status.final_beat) state_in = msf_pkg::ST_I_CHECK;
         end
         msf_pkg::ST_I_CHECK: begin
            if (status.i_done) state_in = msf_pkg::ST_FINISH;
            else if (status.i_live) state_in = msf_pkg::ST_I_WAIT;
         end
         msf_pkg::ST_I_WAIT: begin
            state_in = msf_pkg::ST_J_CHECK;
         end
         msf_pkg::ST_J_CHECK: begin
            if (status.j_done) state_in = msf_pkg::ST_EMIT;
            else if (!status.j_skip) state_in = msf_pkg::ST_J_WAIT;
         end
         msf_pkg::ST_J_WAIT: begin
            state_in = msf_pkg::ST_T_READ;
         end
         msf_pkg::ST_T_READ: begin
            if (status.t_done) state_in = msf_pkg::ST_I_CHECK;
            else state_in = msf_pkg::ST_T_CMP;
         end
         msf_pkg::ST_T_CMP: begin
            if (status.contained) state_in = msf_pkg::ST_T_READ;
            else state_in = msf_pkg::ST_J_CHECK;
         end
         msf_pkg::ST_EMIT: begin
            if (status.out_free) state_in = msf_pkg::ST_I_CHECK;
         end
         msf_pkg::ST_FINISH: begin
            if (status.out_free) state_in = msf_pkg::ST_LOAD;
         end
         default: begin
            state_in = msf_pkg::ST_LOAD;
         end
      endcase
   end

   // command outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         msf_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         msf_pkg::ST_I_CHECK: begin
            if (!status.i_done) begin
               cmd.i_next = !status.i_live;
               cmd.i_read = status.i_live;
            end
         end
         msf_pkg::ST_I_WAIT: begin
            cmd.i_latch = 1'b1;
         end
         msf_pkg::ST_J_CHECK: begin
            if (!status.j_done) begin
               cmd.j_next = status.j_skip;
               cmd.j_read = !status.j_skip;
            end
         end
         msf_pkg::ST_J_WAIT: begin
            cmd.j_latch = 1'b1;
         end
         msf_pkg::ST_T_READ: begin
            if (status.t_done) begin
               // contained over all tetrahedra: strict kills, equal just moves on
               cmd.kill_i = status.strict;
               cmd.i_next = 1'b1;
            end else begin
               cmd.t_read = 1'b1;
            end
         end
         msf_pkg::ST_T_CMP: begin
            cmd.t_step = status.contained;
            cmd.j_next = !status.contained;
         end
         msf_pkg::ST_EMIT: begin
            cmd.emit   = status.out_free;
            cmd.i_next = status.out_free;
         end
         msf_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/msf_datapath.sv @@
// msf_datapath: support and index memories, load counters, live flags,
// pair comparison and output register; depends on msf_pkg

module msf_datapath #(
   parameter int MAX_SURFACES = msf_pkg::MAX_SURFACES_DEF,
   parameter int MAX_TETS     = msf_pkg::MAX_TETS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [msf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [msf_pkg::CSR_DATA_W-1:0]     csr_data,
   input  msf_pkg::req_type                   req_data,
   input  msf_pkg::cmd_type                   cmd,
   output msf_pkg::status_type                status,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output msf_pkg::rsp_type                   rsp_data
);

   localparam int SLOT_W  = $clog2(MAX_SURFACES);
   localparam int CNT_W   = $clog2(MAX_SURFACES + 1);
   localparam int POS_W   = (MAX_TETS > 1) ? $clog2(MAX_TETS) : 1;
   localparam int LEN_W   = $clog2(MAX_TETS + 1);
   localparam int CMP_W   = ((LEN_W > msf_pkg::TET_COUNT_W) ? LEN_W : msf_pkg::TET_COUNT_W) + 1;
   localparam int DEPTH   = MAX_SURFACES * MAX_TETS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = LEN_W + msf_pkg::INDEX_W;
   localparam int SUP_W   = msf_pkg::SUPPORT_W;

   // memories: support per slot and tetrahedron, {length, load index} per slot
   logic [SUP_W-1:0]   support_mem [DEPTH];
   logic [ENTRY_W-1:0] index_mem   [MAX_SURFACES];

   // control registers
   logic                           almost_normal_ff, almost_normal_in;
   logic [msf_pkg::TET_COUNT_W-1:0] tet_count_ff, tet_count_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [CNT_W-1:0]               stored_ff, stored_in;
   logic [msf_pkg::LOAD_CNT_W-1:0] loaded_ff, loaded_in;
   logic                           overflow_ff, overflow_in;
   logic [MAX_SURFACES-1:0]        live_ff, live_in;
   logic [CNT_W-1:0]               i_ff, i_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [CNT_W-1:0]               j_ff, j_in;
   logic [LEN_W-1:0]               t_ff, t_in;
   logic                           strict_ff, strict_in;
   logic [LEN_W-1:0]               ilen_ff, ilen_in;
   logic [msf_pkg::INDEX_W-1:0]    iidx_ff, iidx_in;
   logic [LEN_W-1:0]               jlen_ff, jlen_in;
   logic [msf_pkg::INDEX_W-1:0]    pend_idx_ff, pend_idx_in;
   msf_pkg::rsp_type               rsp_ff, rsp_in;

   // memory read data
   logic [SUP_W-1:0]               rd_a_ff, rd_b_ff;
   logic [ENTRY_W-1:0]             rd_entry_ff;

   logic [CMP_W-1:0]   tc_ext;
   logic [LEN_W-1:0]   n_eff;
   logic               last_rec;
   logic               writable;
   logic [SLOT_W-1:0]  slot;
   logic [SLOT_W-1:0]  i_slot;
   logic [SLOT_W-1:0]  j_slot;
   logic               sup_we;
   logic [ADDR_W-1:0]  sup_waddr;
   logic [ADDR_W-1:0]  sup_raddr_a;
   logic [ADDR_W-1:0]  sup_raddr_b;
   logic [SUP_W-1:0]   mask;
   logic [SUP_W-1:0]   a_val;
   logic [SUP_W-1:0]   b_val;
   logic               idx_we;
   logic [ENTRY_W-1:0] idx_wdata;
   logic [SLOT_W-1:0]  idx_raddr;
   logic               out_free;

   // effective tetrahedron count: zero acts as one, saturate at capacity
   assign tc_ext = CMP_W'(tet_count_ff);
   always_comb begin
      if (tc_ext == '0) n_eff = LEN_W'(1);
      else if (tc_ext > CMP_W'(MAX_TETS)) n_eff = LEN_W'(MAX_TETS);
      else n_eff = tc_ext[LEN_W-1:0];
   end

   // record bookkeeping
   assign last_rec = req_data.final_surface ||
                     ((CMP_W'(pos_ff) + CMP_W'(1)) >= CMP_W'(n_eff));
   assign writable = (stored_ff < CNT_W'(MAX_SURFACES)) && (loaded_ff < msf_pkg::LOAD_LIMIT);
   assign slot     = stored_ff[SLOT_W-1:0];
   assign i_slot   = i_ff[SLOT_W-1:0];
   assign j_slot   = j_ff[SLOT_W-1:0];

   // memory addresses: slot-major layout
   assign sup_we      = cmd.load && writable;
   assign sup_waddr   = ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_TETS)) + ADDR_W'(pos_ff);
   assign sup_raddr_a = ADDR_W'(ADDR_W'(i_slot) * ADDR_W'(MAX_TETS)) + ADDR_W'(t_ff[POS_W-1:0]);
   assign sup_raddr_b = ADDR_W'(ADDR_W'(j_slot) * ADDR_W'(MAX_TETS)) + ADDR_W'(t_ff[POS_W-1:0]);
   assign idx_we      = cmd.load && last_rec && !req_data.vertex_link && writable;
   assign idx_wdata   = {LEN_W'(pos_ff) + LEN_W'(1), loaded_ff[msf_pkg::INDEX_W-1:0]};
   assign idx_raddr   = cmd.i_read ? i_slot : j_slot;

   // support memory, two registered read ports
   always_ff @(posedge clock) begin
      if (sup_we) begin
         support_mem[sup_waddr] <= {req_data.oct_nonzero, req_data.quad_nonzero};
      end
      if (cmd.t_read) begin
         rd_a_ff <= support_mem[sup_raddr_a];
         rd_b_ff <= support_mem[sup_raddr_b];
      end
   end

   // index memory, one registered read port
   always_ff @(posedge clock) begin
      if (idx_we) begin
         index_mem[slot] <= idx_wdata;
      end
      if (cmd.i_read || cmd.j_read) begin
         rd_entry_ff <= index_mem[idx_raddr];
      end
   end

   // masked supports, tetrahedra past a surface's length read as zero
   assign mask  = almost_normal_ff ? msf_pkg::MASK_ALL : msf_pkg::MASK_QUAD;
   assign a_val = (t_ff < ilen_ff) ? (rd_a_ff & mask) : '0;
   assign b_val = (t_ff < jlen_ff) ? (rd_b_ff & mask) : '0;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next values
   always_comb begin
      almost_normal_in = almost_normal_ff;
      tet_count_in     = tet_count_ff;
      pos_in           = pos_ff;
      stored_in        = stored_ff;
      loaded_in        = loaded_ff;
      overflow_in      = overflow_ff;
      live_in          = live_ff;
      i_in             = i_ff;
      pend_valid_in    = pend_valid_ff;
      rsp_valid_in     = rsp_valid_ff;
      j_in             = j_ff;
      t_in             = t_ff;
      strict_in        = strict_ff;
      ilen_in          = ilen_ff;
      iidx_in          = iidx_ff;
      jlen_in          = jlen_ff;
      pend_idx_in      = pend_idx_ff;
      rsp_in           = rsp_ff;

      // configuration writes
      if (csr_write_en) begin
         case (csr_index)
            msf_pkg::CSR_ALMOST_NORMAL: almost_normal_in = csr_data[0];
            msf_pkg::CSR_TET_COUNT:     tet_count_in = csr_data[msf_pkg::TET_COUNT_W-1:0];
            default: ;
         endcase
      end

      // load one record, commit the surface on its last record
      if (cmd.load) begin
         if (!last_rec) begin
            pos_in = pos_ff + POS_W'(1);
         end else begin
            if (!req_data.vertex_link) begin
               if (writable) begin
                  live_in[slot] = 1'b1;
                  stored_in     = stored_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            if (loaded_ff != msf_pkg::LOAD_MAX) loaded_in = loaded_ff + 7'd1;
            pos_in = '0;
         end
      end

      // pair scan
      if (cmd.i_next) i_in = i_ff + CNT_W'(1);
      if (cmd.i_latch) begin
         ilen_in = rd_entry_ff[ENTRY_W-1:msf_pkg::INDEX_W];
         iidx_in = rd_entry_ff[msf_pkg::INDEX_W-1:0];
         j_in    = '0;
      end
      if (cmd.j_next) j_in = j_ff + CNT_W'(1);
      if (cmd.j_latch) begin
         jlen_in   = rd_entry_ff[ENTRY_W-1:msf_pkg::INDEX_W];
         t_in      = '0;
         strict_in = 1'b0;
      end
      if (cmd.t_step) begin
         t_in      = t_ff + LEN_W'(1);
         strict_in = strict_ff || (a_val != b_val);
      end
      if (cmd.kill_i) live_in[i_slot] = 1'b0;

      // output beat: drained first, then refilled
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         // the previous kept surface is known not to be the last one now
         if (pend_valid_ff) begin
            rsp_valid_in           = 1'b1;
            rsp_in.surface_index   = pend_idx_ff;
            rsp_in.none_kept       = 1'b0;
            rsp_in.overflow        = overflow_ff;
            rsp_in.last_result     = 1'b0;
         end
         pend_idx_in   = iidx_ff;
         pend_valid_in = 1'b1;
      end
      if (cmd.finish) begin
         rsp_valid_in         = 1'b1;
         rsp_in.surface_index = pend_valid_ff ? pend_idx_ff : '0;
         rsp_in.none_kept     = !pend_valid_ff;
         rsp_in.overflow      = overflow_ff;
         rsp_in.last_result   = 1'b1;
         // end of run: clear load state and live flags
         pend_valid_in = 1'b0;
         live_in       = '0;
         stored_in     = '0;
         loaded_in     = '0;
         pos_in        = '0;
         overflow_in   = 1'b0;
         i_in          = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         almost_normal_ff <= 1'b0;
         tet_count_ff     <= msf_pkg::TET_COUNT_RESET;
         pos_ff           <= '0;
         stored_ff        <= '0;
         loaded_ff        <= '0;
         overflow_ff      <= 1'b0;
         live_ff          <= '0;
         i_ff             <= '0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         almost_normal_ff <= almost_normal_in;
         tet_count_ff     <= tet_count_in;
         pos_ff           <= pos_in;
         stored_ff        <= stored_in;
         loaded_ff        <= loaded_in;
         overflow_ff      <= overflow_in;
         live_ff          <= live_in;
         i_ff             <= i_in;
         pend_valid_ff    <= pend_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      t_ff        <= t_in;
      strict_ff   <= strict_in;
      ilen_ff     <= ilen_in;
      iidx_ff     <= iidx_in;
      jlen_ff     <= jlen_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   // status to the controller
   always_comb begin
      status.final_beat = req_data.final_surface;
      status.i_done     = (i_ff == stored_ff);
      status.i_live     = live_ff[i_slot];
      status.j_done     = (j_ff == stored_ff);
      status.j_skip     = (j_ff == i_ff) || !live_ff[j_slot];
      status.t_done     = (t_ff == n_eff);
      status.strict     = strict_ff;
      status.contained  = ((b_val & ~a_val) == '0);
      status.out_free   = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // live flags only ever sit at committed slots
   a_live_below_stored: assert property (@(posedge clock) disable iff (reset)
      (live_ff >> stored_ff) == '0)
      else $error("live flag set above stored count");

   // a new beat is only produced when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.finish) |-> out_free)
      else $error("result produced while output register busy");

   // only a live, in-range surface can be killed
   a_kill_live: assert property (@(posedge clock) disable iff (reset)
      cmd.kill_i |-> (live_ff[i_slot] && (i_ff < stored_ff)))
      else $error("kill of a surface that is not live");

   // end of run leaves an empty store behind
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (stored_ff == '0) && (live_ff == '0) && !pend_valid_ff && rsp_valid_ff)
      else $error("run state not cleared after final result");

endmodule
